// ===== rtl/core/esc_servo_pulse_generator_core_defines.svh =====
// Assertion macros used by the checker file of the pulse generator.
`ifndef ESC_SERVO_PULSE_GENERATOR_CORE_DEFINES_SVH
`define ESC_SERVO_PULSE_GENERATOR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ESP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("esp assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define ESP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("esp assertion failed");

`endif

// ===== rtl/core/esp_pkg.sv =====
// Shared types, constants and helpers of the ESC pulse generator.
package esp_pkg;

  localparam int unsigned CHANNELS_DEF = 4;
  localparam int unsigned IO_CH        = 4;
  localparam int unsigned DEMAND_W     = 16;
  localparam int unsigned THR_W        = 8;
  localparam int unsigned CNT_W        = 16;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 16;

  localparam logic [THR_W-1:0] HIGH_VALUE_RST = 8'd200;
  localparam logic [CNT_W-1:0] BASE_TICKS_RST = 16'd280;
  localparam logic [CNT_W-1:0] MIN_PERIOD_RST = 16'd2500;
  localparam logic [CNT_W-1:0] TSS_MAX        = 16'hffff;

  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_VALUE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PERIOD = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PAD  = 2'd1,
    PH_BASE = 2'd2,
    PH_MOD  = 2'd3
  } phase_t;

  typedef struct packed {
    logic [THR_W-1:0] high_value;
    logic [CNT_W-1:0] base_ticks;
    logic [CNT_W-1:0] min_period;
  } cfg_t;

  typedef struct packed {
    logic                          cmd;
    logic [IO_CH-1:0][DEMAND_W-1:0] throttle;
  } item_t;

  typedef struct packed {
    logic [IO_CH-1:0] pulse;
    logic             busy;
    logic             done;
    logic             ignored;
  } result_t;

  // Negative demand -> 0, above the limit -> limit.
  function automatic logic [THR_W-1:0] clamp_demand(input logic [DEMAND_W-1:0] raw,
                                                    input logic [THR_W-1:0]    limit);
    logic [THR_W-1:0] res;
    if (raw[DEMAND_W-1]) begin
      res = '0;
    end else if (raw > {{(DEMAND_W-THR_W){1'b0}}, limit}) begin
      res = limit;
    end else begin
      res = raw[THR_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/esp_in_stage.sv =====
// Input register stage of the ESC pulse generator.
module esp_in_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  esp_pkg::item_t in_item,
  input  logic          take,
  output logic          s_valid,
  output esp_pkg::item_t s_item
);
  import esp_pkg::*;

  assign in_ready = !s_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ready) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s_item <= in_item;
    end
  end

endmodule

// ===== rtl/core/esp_frame_ctrl.sv =====
// Frame sequencer: phase, tick counters, latched throttles and output levels.
module esp_frame_ctrl #(
  parameter int unsigned CHANNELS = esp_pkg::CHANNELS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  esp_pkg::cfg_t    cfg,
  input  logic             take,
  input  esp_pkg::item_t   item,
  output esp_pkg::result_t res
);
  import esp_pkg::*;

  phase_t             phase, phase_next;
  logic [CNT_W-1:0]   step, step_next;
  logic [CNT_W-1:0]   tss, tss_next, tss_inc;
  logic [THR_W-1:0]   thr      [CHANNELS];
  logic [THR_W-1:0]   thr_next [CHANNELS];
  logic [THR_W-1:0]   thr_in   [CHANNELS];
  logic [CHANNELS-1:0] level, level_next;
  logic               begin_frame;
  logic               done;
  logic               ignored;

  for (genvar k = 0; k < CHANNELS; k++) begin : g_thr_in
    if (k < IO_CH) begin : g_io
      assign thr_in[k] = clamp_demand(item.throttle[k], cfg.high_value);
    end else begin : g_none
      assign thr_in[k] = '0;
    end
  end

  assign tss_inc = (tss == TSS_MAX) ? tss : tss + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      step  <= '0;
      tss   <= TSS_MAX;
      level <= '0;
      for (int k = 0; k < CHANNELS; k++) begin
        thr[k] <= '0;
      end
    end else if (take) begin
      phase <= phase_next;
      step  <= step_next;
      tss   <= tss_next;
      level <= level_next;
      for (int k = 0; k < CHANNELS; k++) begin
        thr[k] <= thr_next[k];
      end
    end
  end

  always_comb begin
    phase_next  = phase;
    step_next   = step;
    tss_next    = tss;
    level_next  = level;
    thr_next    = thr;
    begin_frame = 1'b0;
    done        = 1'b0;
    ignored     = 1'b0;

    if (item.cmd) begin
      if (phase != PH_IDLE) begin
        ignored = 1'b1;
      end else begin
        thr_next = thr_in;
        if (tss >= cfg.min_period) begin
          begin_frame = 1'b1;
        end else begin
          phase_next = PH_PAD;
        end
      end
    end else begin
      tss_next = tss_inc;
      unique case (phase)
        PH_IDLE: ;
        PH_PAD: begin
          if (tss_inc >= cfg.min_period) begin
            begin_frame = 1'b1;
          end
        end
        PH_BASE: begin
          step_next = step + CNT_W'(1);
          if (step_next >= cfg.base_ticks) begin
            step_next  = '0;
            phase_next = PH_MOD;
          end
        end
        PH_MOD: begin
          for (int k = 0; k < CHANNELS; k++) begin
            if ({{(CNT_W-THR_W){1'b0}}, thr[k]} == step) begin
              level_next[k] = 1'b0;
            end
          end
          if (step >= {{(CNT_W-THR_W){1'b0}}, cfg.high_value}) begin
            level_next = '0;
            step_next  = '0;
            phase_next = PH_IDLE;
            done       = 1'b1;
          end else begin
            step_next = step + CNT_W'(1);
          end
        end
        default: ;
      endcase
    end

    if (begin_frame) begin
      level_next = '1;
      tss_next   = '0;
      step_next  = '0;
      phase_next = (cfg.base_ticks == '0) ? PH_MOD : PH_BASE;
    end
  end

  for (genvar k = 0; k < IO_CH; k++) begin : g_pulse
    if (k < CHANNELS) begin : g_used
      assign res.pulse[k] = level_next[k];
    end else begin : g_unused
      assign res.pulse[k] = 1'b0;
    end
  end

  assign res.busy    = (phase_next != PH_IDLE);
  assign res.done    = done;
  assign res.ignored = ignored;

endmodule

// ===== rtl/core/esp_out_reg.sv =====
// Result register of the ESC pulse generator.
module esp_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  esp_pkg::result_t res_in,
  output logic             can_load,
  output logic             out_valid,
  input  logic             out_ready,
  output esp_pkg::result_t res
);
  import esp_pkg::*;

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_in;
    end
  end

endmodule

// ===== rtl/core/esc_servo_pulse_generator_core.sv =====
// An accepted word passes the input register, then the result register; it waits while that is full.
// Throughput: one word per cycle while out_ready stays high; each word is a tick or a start.
// The per-word update is one compare/increment pass of the frame sequencer.
// Reset (rst, synchronous): idle, channel levels low, out_valid low, elapsed-tick count saturated,
// registers to high_value 200, base_ticks 280, min_period_ticks 2500.
module esc_servo_pulse_generator_core #(
  parameter int unsigned CHANNELS = esp_pkg::CHANNELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // input words
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              cmd,
  input  logic signed [esp_pkg::DEMAND_W-1:0] throttle_a,
  input  logic signed [esp_pkg::DEMAND_W-1:0] throttle_b,
  input  logic signed [esp_pkg::DEMAND_W-1:0] throttle_c,
  input  logic signed [esp_pkg::DEMAND_W-1:0] throttle_d,
  // result words
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              pulse_a,
  output logic                              pulse_b,
  output logic                              pulse_c,
  output logic                              pulse_d,
  output logic                              busy_res,
  output logic                              frame_done,
  output logic                              start_ignored,
  // register writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [esp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [esp_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import esp_pkg::*;

  cfg_t    cfg;
  item_t   in_item;
  item_t   s_item;
  logic    s_valid;
  logic    take;
  logic    can_load;
  result_t res_next;
  result_t res;

  // Register writes always land at once; the user must issue them only while idle (not enforced here).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.high_value <= HIGH_VALUE_RST;
      cfg.base_ticks <= BASE_TICKS_RST;
      cfg.min_period <= MIN_PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_HIGH_VALUE: cfg.high_value <= cfg_data[THR_W-1:0];
        CFG_BASE_TICKS: cfg.base_ticks <= cfg_data;
        CFG_MIN_PERIOD: cfg.min_period <= cfg_data;
        default: ;  // unknown index: dropped
      endcase
    end
  end

  // Field k of the word goes to channel k.
  assign in_item.cmd         = cmd;
  assign in_item.throttle[0] = throttle_a;
  assign in_item.throttle[1] = throttle_b;
  assign in_item.throttle[2] = throttle_c;
  assign in_item.throttle[3] = throttle_d;

  esp_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .take     (take),
    .s_valid  (s_valid),
    .s_item   (s_item)
  );

  // A held word is processed as soon as the result register has room.
  assign take = s_valid && can_load;

  esp_frame_ctrl #(
    .CHANNELS (CHANNELS)
  ) u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .take (take),
    .item (s_item),
    .res  (res_next)
  );

  esp_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (take),
    .res_in    (res_next),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign pulse_a       = res.pulse[0];
  assign pulse_b       = res.pulse[1];
  assign pulse_c       = res.pulse[2];
  assign pulse_d       = res.pulse[3];
  assign busy_res      = res.busy;
  assign frame_done    = res.done;
  assign start_ignored = res.ignored;

endmodule

// ===== rtl/core/esp_checker.sv =====
// Port-level checker of the ESC pulse generator, bound to the top level.
`include "esc_servo_pulse_generator_core_defines.svh"

module esp_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic pulse_a,
  input logic pulse_b,
  input logic pulse_c,
  input logic pulse_d,
  input logic busy_res,
  input logic frame_done,
  input logic start_ignored
);

  // Outside a frame every channel is low.
  `ESP_ASSERT_NOW(a_idle_low, out_valid && !busy_res, !pulse_a && !pulse_b && !pulse_c && !pulse_d)

  // The closing tick returns the block to idle.
  `ESP_ASSERT_NOW(a_done_idle, out_valid && frame_done, !busy_res)

  // A start is only dropped while a frame is in progress, and never on a closing tick.
  `ESP_ASSERT_NOW(a_drop_busy, out_valid && start_ignored, busy_res && !frame_done)

  // A stalled result word holds.
  `ESP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(busy_res) && $stable(pulse_a) && $stable(frame_done))

endmodule

bind esc_servo_pulse_generator_core esp_checker u_esp_checker (.*);
